>>> design/ale_pkg.sv
// ----------------------------------------------------------------------------
// ale_pkg
// Shared sizes, operation and status codes, and the bundles that pass
// between the list engine modules.
// ----------------------------------------------------------------------------
package ale_pkg;

  localparam int DEPTH      = 64;
  localparam int ELEM_WIDTH = 32;
  localparam int IDX_W      = $clog2(DEPTH);
  localparam int CNT_W      = $clog2(DEPTH + 1);
  localparam int MODE_W     = 3;
  localparam int POS_W      = 7;
  localparam int VAL_W      = 32;
  localparam int STAT_W     = 2;

  localparam logic [CNT_W-1:0] DEPTH_CNT = CNT_W'(DEPTH);

  // operation codes
  localparam logic [MODE_W-1:0] M_APPEND = 3'd0;
  localparam logic [MODE_W-1:0] M_POP    = 3'd1;
  localparam logic [MODE_W-1:0] M_READ   = 3'd2;
  localparam logic [MODE_W-1:0] M_WRITE  = 3'd3;
  localparam logic [MODE_W-1:0] M_INSERT = 3'd4;
  localparam logic [MODE_W-1:0] M_DELETE = 3'd5;

  // status codes
  localparam logic [STAT_W-1:0] ST_OK    = 2'd0;
  localparam logic [STAT_W-1:0] ST_RANGE = 2'd1;
  localparam logic [STAT_W-1:0] ST_EMPTY = 2'd2;
  localparam logic [STAT_W-1:0] ST_FULL  = 2'd3;

  // memory port request from the sequencer
  typedef struct packed {
    logic                  we;
    logic [IDX_W-1:0]      waddr;
    logic [ELEM_WIDTH-1:0] wdata;
    logic                  re;
    logic [IDX_W-1:0]      raddr;
  } ram_req_t;

  // finished result of one request
  typedef struct packed {
    logic [VAL_W-1:0]  value;
    logic [STAT_W-1:0] status;
    logic [CNT_W-1:0]  count;
  } res_t;

endpackage

>>> design/ale_if.sv
// ----------------------------------------------------------------------------
// ale_if
// Valid/ready channels for list requests and list results.
// ----------------------------------------------------------------------------
interface ale_req_if;
  logic                          valid;
  logic                          ready;
  logic [ale_pkg::MODE_W-1:0]    mode;
  logic [ale_pkg::POS_W-1:0]     position;
  logic [ale_pkg::ELEM_WIDTH-1:0] element;

  modport source (output valid, mode, position, element, input ready);
  modport sink   (input valid, mode, position, element, output ready);
endinterface

interface ale_rsp_if;
  logic                       valid;
  logic                       ready;
  logic [ale_pkg::VAL_W-1:0]  read_value;
  logic [ale_pkg::STAT_W-1:0] status;
  logic [ale_pkg::CNT_W-1:0]  count;

  modport source (output valid, read_value, status, count, input ready);
  modport sink   (input valid, read_value, status, count, output ready);
endinterface

>>> design/ale_ram.sv
// ----------------------------------------------------------------------------
// ale_ram
// Simple dual-port RAM: one write port, one read port with registered data.
// ----------------------------------------------------------------------------
module ale_ram #(
  parameter int DEPTH = 64,
  parameter int WIDTH = 32,
  localparam int AW = $clog2(DEPTH)
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic             re,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
  end

  // read port, registered data in the cycle after the address
  always_ff @(posedge clk) begin
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

>>> design/ale_seq.sv
// ----------------------------------------------------------------------------
// ale_seq
// Request sequencer: checks each request against the fill count, drives the
// element memory and walks the shift one element per cycle.
// ----------------------------------------------------------------------------
module ale_seq (
  input  logic                             clk,
  input  logic                             rst,
  ale_req_if.sink                          req,
  output ale_pkg::ram_req_t                ram,
  input  logic [ale_pkg::ELEM_WIDTH-1:0]   rdata,
  output logic                             res_valid,
  input  logic                             res_ready,
  output ale_pkg::res_t                    res
);

  localparam logic [2:0] S_IDLE   = 3'd0;
  localparam logic [2:0] S_EXEC   = 3'd1;
  localparam logic [2:0] S_SHIFT  = 3'd2;
  localparam logic [2:0] S_FINAL  = 3'd3;
  localparam logic [2:0] S_RDWAIT = 3'd4;
  localparam logic [2:0] S_RESP   = 3'd5;

  localparam int IW = ale_pkg::IDX_W;
  localparam int CW = ale_pkg::CNT_W;

  logic [2:0]                       state, state_next;
  logic [ale_pkg::MODE_W-1:0]       mode, mode_next;
  logic [ale_pkg::POS_W-1:0]        pos, pos_next;
  logic [ale_pkg::ELEM_WIDTH-1:0]   elem, elem_next;
  logic [CW-1:0]                    cnt, cnt_next;
  logic [IW-1:0]                    rd_addr, rd_addr_next;
  logic [IW-1:0]                    rd_end, rd_end_next;
  logic                             rd_active, rd_active_next;
  logic                             wr_pend, wr_pend_next;
  logic [IW-1:0]                    wr_addr, wr_addr_next;
  logic [ale_pkg::VAL_W-1:0]        value, value_next;
  logic [ale_pkg::STAT_W-1:0]       status, status_next;

  logic [CW-1:0] cnt_last;
  logic [IW-1:0] idx_last;
  logic [IW-1:0] pos_idx;
  logic [CW-1:0] pos_cnt;
  logic          is_full;
  logic          is_empty;
  logic          is_ins;

  // compares and index forms shared among the operations
  assign cnt_last = cnt - CW'(1);
  assign idx_last = cnt_last[IW-1:0];
  assign pos_idx  = pos[IW-1:0];
  assign pos_cnt  = CW'(pos);
  assign is_full  = (cnt == ale_pkg::DEPTH_CNT);
  assign is_empty = (cnt == '0);
  assign is_ins   = (mode == ale_pkg::M_INSERT);

  assign req.ready = (state == S_IDLE);
  assign res_valid = (state == S_RESP);
  assign res.value  = value;
  assign res.status = status;
  assign res.count  = cnt;

  // sequencer next state and memory port control
  always_comb begin
    state_next     = state;
    mode_next      = mode;
    pos_next       = pos;
    elem_next      = elem;
    cnt_next       = cnt;
    rd_addr_next   = rd_addr;
    rd_end_next    = rd_end;
    rd_active_next = rd_active;
    wr_pend_next   = wr_pend;
    wr_addr_next   = wr_addr;
    value_next     = value;
    status_next    = status;
    ram.we    = 1'b0;
    ram.waddr = '0;
    ram.wdata = elem;
    ram.re    = 1'b0;
    ram.raddr = '0;

    unique case (state)
      S_IDLE: begin
        if (req.valid) begin
          mode_next  = req.mode;
          pos_next   = req.position;
          elem_next  = req.element;
          state_next = S_EXEC;
        end
      end

      S_EXEC: begin
        value_next  = '0;
        status_next = ale_pkg::ST_OK;
        state_next  = S_RESP;
        case (mode)
          ale_pkg::M_APPEND: begin
            if (is_full) begin
              status_next = ale_pkg::ST_FULL;
            end else begin
              ram.we    = 1'b1;
              ram.waddr = cnt[IW-1:0];
              cnt_next  = cnt + CW'(1);
            end
          end
          ale_pkg::M_POP: begin
            if (is_empty) begin
              status_next = ale_pkg::ST_EMPTY;
            end else begin
              ram.re     = 1'b1;
              ram.raddr  = idx_last;
              cnt_next   = cnt_last;
              state_next = S_RDWAIT;
            end
          end
          ale_pkg::M_READ: begin
            if (pos_cnt >= cnt || pos > ale_pkg::POS_W'(ale_pkg::DEPTH)) begin
              status_next = ale_pkg::ST_RANGE;
            end else begin
              ram.re     = 1'b1;
              ram.raddr  = pos_idx;
              state_next = S_RDWAIT;
            end
          end
          ale_pkg::M_WRITE: begin
            if (pos_cnt >= cnt || pos > ale_pkg::POS_W'(ale_pkg::DEPTH)) begin
              status_next = ale_pkg::ST_RANGE;
            end else begin
              ram.we    = 1'b1;
              ram.waddr = pos_idx;
            end
          end
          ale_pkg::M_INSERT: begin
            if (pos_cnt > cnt || pos > ale_pkg::POS_W'(ale_pkg::DEPTH)) begin
              status_next = ale_pkg::ST_RANGE;
            end else if (is_full) begin
              status_next = ale_pkg::ST_FULL;
            end else if (pos_cnt == cnt) begin
              // insert at the end is an append
              ram.we    = 1'b1;
              ram.waddr = pos_idx;
              cnt_next  = cnt + CW'(1);
            end else begin
              // move entries pos..cnt-1 up, starting from the top
              rd_addr_next   = idx_last;
              rd_end_next    = pos_idx;
              rd_active_next = 1'b1;
              wr_pend_next   = 1'b0;
              state_next     = S_SHIFT;
            end
          end
          ale_pkg::M_DELETE: begin
            if (pos_cnt >= cnt || pos > ale_pkg::POS_W'(ale_pkg::DEPTH)) begin
              status_next = ale_pkg::ST_RANGE;
            end else if (pos_cnt == cnt_last) begin
              // last element: nothing to move
              cnt_next = cnt_last;
            end else begin
              // move entries pos+1..cnt-1 down, starting from the bottom
              rd_addr_next   = pos_idx + IW'(1);
              rd_end_next    = idx_last;
              rd_active_next = 1'b1;
              wr_pend_next   = 1'b0;
              state_next     = S_SHIFT;
            end
          end
          default: begin
            status_next = ale_pkg::ST_OK;
          end
        endcase
      end

      S_SHIFT: begin
        // write back the element read in the previous cycle
        if (wr_pend) begin
          ram.we    = 1'b1;
          ram.waddr = wr_addr;
          ram.wdata = rdata;
        end
        if (rd_active) begin
          ram.re       = 1'b1;
          ram.raddr    = rd_addr;
          wr_pend_next = 1'b1;
          wr_addr_next = is_ins ? rd_addr + IW'(1) : rd_addr - IW'(1);
          if (rd_addr == rd_end) begin
            rd_active_next = 1'b0;
          end else begin
            rd_addr_next = is_ins ? rd_addr - IW'(1) : rd_addr + IW'(1);
          end
        end else begin
          wr_pend_next = 1'b0;
          state_next   = S_FINAL;
        end
      end

      S_FINAL: begin
        if (is_ins) begin
          ram.we    = 1'b1;
          ram.waddr = pos_idx;
          cnt_next  = cnt + CW'(1);
        end else begin
          cnt_next = cnt_last;
        end
        state_next = S_RESP;
      end

      S_RDWAIT: begin
        value_next = rdata;
        state_next = S_RESP;
      end

      S_RESP: begin
        if (res_ready) begin
          state_next = S_IDLE;
        end
      end

      default: begin
        state_next = S_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= S_IDLE;
      cnt       <= '0;
      rd_active <= 1'b0;
      wr_pend   <= 1'b0;
    end else begin
      state     <= state_next;
      cnt       <= cnt_next;
      rd_active <= rd_active_next;
      wr_pend   <= wr_pend_next;
    end
  end

  // request and result payload
  always_ff @(posedge clk) begin
    mode    <= mode_next;
    pos     <= pos_next;
    elem    <= elem_next;
    rd_addr <= rd_addr_next;
    rd_end  <= rd_end_next;
    wr_addr <= wr_addr_next;
    value   <= value_next;
    status  <= status_next;
  end

endmodule

>>> design/array_list_engine.sv
// ----------------------------------------------------------------------------
// array_list_engine
// Ordered list of elements in a fixed store with append, pop, read, write,
// insert and delete.
// ----------------------------------------------------------------------------
// One request is taken at a time and gives exactly one result. Append, write
// and any rejected request go from the execute state straight to the result;
// pop and read first pass a read-wait state. Insert and delete that move
// n > 0 elements pass a shift state and then a final state, and the single
// read and single write port of the element memory move one element per
// cycle. The result sits in an output register, so the next request is
// taken while it waits. After reset the list is empty at once; the memory is
// never cleared, as only entries below the count are ever read.
module array_list_engine (
  input  logic      clk,
  input  logic      rst,
  ale_req_if.sink   req,
  ale_rsp_if.source rsp
);

  ale_pkg::ram_req_t               ram;
  logic [ale_pkg::ELEM_WIDTH-1:0]  rdata;
  logic                            res_valid;
  logic                            res_ready;
  ale_pkg::res_t                   res;
  logic                            out_valid;

  ale_seq u_seq (
    .clk       (clk),
    .rst       (rst),
    .req       (req),
    .ram       (ram),
    .rdata     (rdata),
    .res_valid (res_valid),
    .res_ready (res_ready),
    .res       (res)
  );

  ale_ram #(
    .DEPTH (ale_pkg::DEPTH),
    .WIDTH (ale_pkg::ELEM_WIDTH)
  ) u_ram (
    .clk   (clk),
    .we    (ram.we),
    .waddr (ram.waddr),
    .wdata (ram.wdata),
    .re    (ram.re),
    .raddr (ram.raddr),
    .rdata (rdata)
  );

  // output register, loads when empty or being drained
  assign res_ready = !out_valid || rsp.ready;
  assign rsp.valid = out_valid;

  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (res_ready) begin
      out_valid <= res_valid;
    end
  end

  always_ff @(posedge clk) begin
    if (res_ready && res_valid) begin
      rsp.read_value <= res.value;
      rsp.status     <= res.status;
      rsp.count      <= res.count;
    end
  end

endmodule

>>> design/ale_checker.sv
// ----------------------------------------------------------------------------
// ale_checker
// Port-level checks on the list engine: one request at a time and results
// that agree with the count.
// ----------------------------------------------------------------------------
module ale_checker (
  input logic                       clk,
  input logic                       rst,
  input logic                       req_valid,
  input logic                       req_ready,
  input logic                       rsp_valid,
  input logic                       rsp_ready,
  input logic [ale_pkg::STAT_W-1:0] rsp_status,
  input logic [ale_pkg::CNT_W-1:0]  rsp_count
);

  // a held result stays until it is taken
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && !rsp_ready |=> rsp_valid)
    else $error("result dropped before transfer");

  // the engine works on one request at a time
  a_one_at_a_time: assert property (@(posedge clk) disable iff (rst)
    req_valid && req_ready |=> !req_ready)
    else $error("request taken while busy");

  // count never passes the depth
  a_count_bound: assert property (@(posedge clk) disable iff (rst)
    rsp_valid |-> rsp_count <= ale_pkg::DEPTH_CNT)
    else $error("count above depth");

  // empty status only with an empty list
  a_empty_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ale_pkg::ST_EMPTY |-> rsp_count == '0)
    else $error("empty status with elements held");

  // full status only with a full list
  a_full_count: assert property (@(posedge clk) disable iff (rst)
    rsp_valid && rsp_status == ale_pkg::ST_FULL |-> rsp_count == ale_pkg::DEPTH_CNT)
    else $error("full status with room left");

endmodule

bind array_list_engine ale_checker u_ale_checker (
  .clk        (clk),
  .rst        (rst),
  .req_valid  (req.valid),
  .req_ready  (req.ready),
  .rsp_valid  (rsp.valid),
  .rsp_ready  (rsp.ready),
  .rsp_status (rsp.status),
  .rsp_count  (rsp.count)
);
